// File: rtl/core/oaht_pkg.sv
// oaht_pkg: shared types and constants of the open addressing hash table
// item and result structs, controller/datapath command and status structs, codes
// no dependencies
package oaht_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_MULT  = 32'd16777619;
    localparam int SLOT_W = 10;

    localparam logic [1:0] CFG_GROW      = 2'd0;
    localparam logic [1:0] CFG_SHRINK    = 2'd1;
    localparam logic [1:0] CFG_TOMBSTONE = 2'd2;

    typedef enum logic [1:0] {
        KIND_SEARCH = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_FETCH  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_EXHAUSTED = 3'd4,
        ST_RANGE     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        FLAG_EMPTY = 2'd0,
        FLAG_USED  = 2'd1,
        FLAG_TOMB  = 2'd2
    } t_flag;

    typedef enum logic [1:0] {
        RD_PROBE = 2'd0,
        RD_CNT   = 2'd1,
        RD_SLOT  = 2'd2
    } t_rd_sel;

    typedef enum logic [1:0] {
        LIM_SIZE = 2'd0,
        LIM_CLR  = 2'd1,
        LIM_NUM  = 2'd2
    } t_lim_sel;

    typedef enum logic [4:0] {
        S_RST_CLR,
        S_IDLE,
        S_FETCH,
        S_FETCH_W,
        S_HASH,
        S_FIND_RD,
        S_FIND_CK,
        S_GROW,
        S_PLACE_START,
        S_PLC_RD,
        S_PLC_CK,
        S_INS_FIN,
        S_RM_CHK1,
        S_RM_CHK2,
        S_SCAN_CK,
        S_SCAN_W,
        S_CLR,
        S_RI_CHK,
        S_RI_LD
    } t_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       key;
        logic [31:0]       new_value;
        logic [SLOT_W-1:0] slot_in;
    } t_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_out;
        logic [31:0]       found_value;
        logic [10:0]       table_size;
        logic [10:0]       active_count;
    } t_result;

    typedef struct packed {
        t_flag       flag;
        logic [31:0] key;
        logic [31:0] val;
    } t_entry;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] val;
    } t_pair;

    typedef struct packed {
        logic     latch;
        logic     ld_wk_req;
        logic     ld_wk_scr;
        logic     hash_step;
        logic     probe_init;
        logic     probe_next;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_place;
        logic     wr_tomb;
        logic     wr_clr;
        logic     scr_wr;
        logic     scr_rd;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     n_clr;
        logic     ld_lim;
        t_lim_sel lim_sel;
        logic     rb_start;
        logic     rb_grow;
        logic     set_size;
        logic     fin;
        t_status  fin_status;
        logic     fin_slot;
        logic     fin_fval;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  hash_done;
        logic  rd_used;
        logic  rd_empty;
        logic  key_match;
        logic  probe_last;
        logic  cnt_at_lim;
        logic  range_bad;
        logic  grow_need;
        logic  shrink_need;
        logic  tomb_need;
    } t_stat;

endpackage

// File: rtl/core/oaht_dp.sv
// oaht_dp: datapath of the hash table: slot memory, scratch memory, fnv-1a unit,
// probe and sweep counters, load tests and result register
// depends on oaht_pkg
module oaht_dp #(
    parameter int MAX_SLOTS = 1024,
    parameter int KEY_BYTES = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  oaht_pkg::t_item i_item,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [8:0]      i_cfg_data,
    input  oaht_pkg::t_cmd  i_cmd,
    output oaht_pkg::t_stat o_stat,
    output logic            o_done,
    output oaht_pkg::t_result o_result
);
    import oaht_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int SW = AW + 1;
    localparam int LW = $clog2(AW + 1);
    localparam int HW = $clog2(KEY_BYTES + 1);
    localparam int CW = AW + 10;
    localparam int MW = (SW > SLOT_W) ? SW : SLOT_W;

    t_entry r_tbl_mem [MAX_SLOTS];
    t_pair  r_scr_mem [MAX_SLOTS];

    t_item         r_req;
    logic [31:0]   r_wk_key;
    logic [31:0]   r_wk_val;
    logic [31:0]   r_h;
    logic [HW-1:0] r_hcnt;
    logic [SW-1:0] r_pi;
    logic [SW-1:0] r_cnt;
    logic [SW-1:0] r_lim;
    logic [SW-1:0] r_n;
    logic [LW-1:0] r_log2;
    logic [LW-1:0] r_new_log2;
    logic [SW-1:0] r_used;
    logic [SW-1:0] r_live;
    logic [8:0]    r_gf;
    logic [7:0]    r_sf;
    logic [7:0]    r_tf;
    t_entry        r_rd;
    t_pair         r_scr_rd;

    logic [SW-1:0] size;
    logic [SW-1:0] tgt_size;
    logic [SW-1:0] clr_lim;
    logic [AW-1:0] mask;
    logic [AW-1:0] probe_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          tbl_we;
    logic [7:0]    hbyte;
    logic [31:0]   hx;
    logic [SW-1:0] lim_next;
    logic [LW-1:0] shrink_log2;

    assign size       = SW'(1) << r_log2;
    assign tgt_size   = SW'(1) << r_new_log2;
    assign clr_lim    = (r_new_log2 > r_log2) ? tgt_size : size;
    assign mask       = AW'(size - SW'(1));
    assign probe_addr = (r_h[AW-1:0] + r_pi[AW-1:0]) & mask;
    assign hbyte      = 8'(r_wk_key >> {r_hcnt, 3'b000});
    assign hx         = r_h ^ {24'd0, hbyte};
    assign shrink_log2 = (r_log2 > LW'(1)) ? r_log2 - LW'(1) : LW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PROBE: rd_addr = probe_addr;
            RD_CNT:   rd_addr = r_cnt[AW-1:0];
            RD_SLOT:  rd_addr = AW'(r_req.slot_in);
            default:  rd_addr = probe_addr;
        endcase
    end

    always_comb begin
        case (i_cmd.lim_sel)
            LIM_SIZE: lim_next = size;
            LIM_CLR:  lim_next = clr_lim;
            LIM_NUM:  lim_next = r_n;
            default:  lim_next = size;
        endcase
    end

    assign tbl_we  = i_cmd.wr_place | i_cmd.wr_tomb | i_cmd.wr_clr;
    assign wr_addr = i_cmd.wr_clr ? r_cnt[AW-1:0] : probe_addr;

    always_comb begin
        wr_data = '0;
        if (i_cmd.wr_place) begin
            wr_data = '{flag: FLAG_USED, key: r_wk_key, val: r_wk_val};
        end else if (i_cmd.wr_tomb) begin
            wr_data = '{flag: FLAG_TOMB, key: r_rd.key, val: r_rd.val};
        end
    end

    // slot and scratch memories, registered read
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_tbl_mem[rd_addr];
        end
        if (i_cmd.scr_wr) begin
            r_scr_mem[r_n[AW-1:0]] <= '{key: r_rd.key, val: r_rd.val};
        end
        if (i_cmd.scr_rd) begin
            r_scr_rd <= r_scr_mem[r_cnt[AW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req    <= i_item;
            r_wk_key <= i_item.key;
            r_wk_val <= i_item.new_value;
            r_h      <= FNV_BASIS;
        end else if (i_cmd.ld_wk_req) begin
            r_wk_key <= r_req.key;
            r_wk_val <= r_req.new_value;
            r_h      <= FNV_BASIS;
        end else if (i_cmd.ld_wk_scr) begin
            r_wk_key <= r_scr_rd.key;
            r_wk_val <= r_scr_rd.val;
            r_h      <= FNV_BASIS;
        end else if (i_cmd.hash_step) begin
            r_h <= hx * FNV_MULT;
        end
        if (i_cmd.rb_start) begin
            r_new_log2 <= i_cmd.rb_grow ? r_log2 + LW'(1) : shrink_log2;
        end
        if (i_cmd.fin) begin
            o_result.status       <= 3'(i_cmd.fin_status);
            o_result.slot_out     <= i_cmd.fin_slot ? SLOT_W'(probe_addr) : '0;
            o_result.found_value  <= (i_cmd.fin_fval && r_rd.flag != FLAG_EMPTY) ?
                                     r_rd.val : 32'd0;
            o_result.table_size   <= 11'(size);
            o_result.active_count <= 11'(r_live);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= '0;
            r_pi   <= '0;
            r_cnt  <= '0;
            r_lim  <= SW'(MAX_SLOTS);
            r_n    <= '0;
            r_log2 <= LW'(1);
            r_used <= '0;
            r_live <= '0;
            r_gf   <= 9'd192;
            r_sf   <= 8'd64;
            r_tf   <= 8'd128;
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.fin;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GROW:      r_gf <= i_cfg_data;
                    CFG_SHRINK:    r_sf <= i_cfg_data[7:0];
                    CFG_TOMBSTONE: r_tf <= i_cfg_data[7:0];
                    default:       r_gf <= r_gf;
                endcase
            end
            if (i_cmd.latch || i_cmd.ld_wk_req || i_cmd.ld_wk_scr) begin
                r_hcnt <= '0;
            end else if (i_cmd.hash_step) begin
                r_hcnt <= r_hcnt + HW'(1);
            end
            if (i_cmd.probe_init) begin
                r_pi <= '0;
            end else if (i_cmd.probe_next) begin
                r_pi <= r_pi + SW'(1);
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + SW'(1);
            end
            if (i_cmd.ld_lim) begin
                r_lim <= lim_next;
            end
            if (i_cmd.n_clr) begin
                r_n <= '0;
            end else if (i_cmd.scr_wr) begin
                r_n <= r_n + SW'(1);
            end
            if (i_cmd.set_size) begin
                r_log2 <= r_new_log2;
                r_used <= '0;
                r_live <= '0;
            end else if (i_cmd.wr_place) begin
                r_live <= r_live + SW'(1);
                if (r_rd.flag == FLAG_EMPTY) begin
                    r_used <= r_used + SW'(1);
                end
            end else if (i_cmd.wr_tomb) begin
                r_live <= r_live - SW'(1);
            end
        end
    end

    always_comb begin
        o_stat.kind        = t_kind'(r_req.kind);
        o_stat.hash_done   = (r_hcnt == HW'(KEY_BYTES));
        o_stat.rd_used     = (r_rd.flag == FLAG_USED);
        o_stat.rd_empty    = (r_rd.flag == FLAG_EMPTY);
        o_stat.key_match   = (r_rd.key == r_wk_key);
        o_stat.probe_last  = (r_pi == size - SW'(1));
        o_stat.cnt_at_lim  = (r_cnt == r_lim);
        o_stat.range_bad   = (MW'(r_req.slot_in) >= MW'(size));
        o_stat.grow_need   = (((CW'(r_used) + CW'(1)) << 8) > (CW'(r_gf) << r_log2)) &&
                             (r_log2 < LW'(AW));
        o_stat.shrink_need = (CW'(r_live) << 8) < (CW'(r_sf) << r_log2);
        o_stat.tomb_need   = (CW'(r_live) << 8) < (CW'(r_used) * CW'(r_tf));
    end

endmodule

// File: rtl/core/oaht_ctrl.sv
// oaht_ctrl: sequencer of the hash table: probe loops, insert and remove flows,
// rebuild (collect, clear, re-insert) and the clearing pass after reset
// depends on oaht_pkg
module oaht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  oaht_pkg::t_stat i_stat,
    output oaht_pkg::t_cmd  o_cmd
);
    import oaht_pkg::*;

    typedef enum logic [1:0] {
        RET_PLACE = 2'd0,
        RET_RM2   = 2'd1,
        RET_FIN   = 2'd2
    } t_ret;

    typedef enum logic [1:0] {
        MODE_FIND  = 2'd0,
        MODE_PLACE = 2'd1,
        MODE_REB   = 2'd2
    } t_mode;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
            r_ret   <= RET_FIN;
            r_mode  <= MODE_FIND;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_mode  = r_mode;
        case (r_state)
            S_RST_CLR: begin
                if (i_stat.cnt_at_lim) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_mode  = MODE_FIND;
                    n_state = S_FETCH;
                end
            end
            // item is latched now: fetch goes its own way, everything else hashes
            S_FETCH: begin
                if (i_stat.kind != KIND_FETCH) begin
                    n_state = S_HASH;
                end else begin
                    n_state = i_stat.range_bad ? S_IDLE : S_FETCH_W;
                end
            end
            S_FETCH_W: n_state = S_IDLE;
            S_HASH: begin
                if (i_stat.hash_done) begin
                    n_state = (r_mode == MODE_FIND) ? S_FIND_RD : S_PLC_RD;
                end
            end
            S_FIND_RD: n_state = S_FIND_CK;
            S_FIND_CK: begin
                if (i_stat.rd_used && i_stat.key_match) begin
                    case (i_stat.kind)
                        KIND_REMOVE: n_state = S_RM_CHK1;
                        default:     n_state = S_IDLE;
                    endcase
                end else if (i_stat.rd_empty || i_stat.probe_last) begin
                    n_state = (i_stat.kind == KIND_INSERT) ? S_GROW : S_IDLE;
                end else begin
                    n_state = S_FIND_RD;
                end
            end
            S_GROW: begin
                if (i_stat.grow_need) begin
                    n_ret   = RET_PLACE;
                    n_state = S_SCAN_CK;
                end else begin
                    n_state = S_PLACE_START;
                end
            end
            S_PLACE_START: begin
                n_mode  = MODE_PLACE;
                n_state = S_HASH;
            end
            S_PLC_RD: n_state = S_PLC_CK;
            S_PLC_CK: begin
                if (!i_stat.rd_used || i_stat.probe_last) begin
                    if (r_mode == MODE_REB) begin
                        n_state = S_RI_CHK;
                    end else begin
                        n_state = !i_stat.rd_used ? S_INS_FIN : S_IDLE;
                    end
                end else begin
                    n_state = S_PLC_RD;
                end
            end
            S_INS_FIN: n_state = S_IDLE;
            S_RM_CHK1: begin
                if (i_stat.shrink_need) begin
                    n_ret   = RET_RM2;
                    n_state = S_SCAN_CK;
                end else begin
                    n_state = S_RM_CHK2;
                end
            end
            S_RM_CHK2: begin
                if (i_stat.tomb_need) begin
                    n_ret   = RET_FIN;
                    n_state = S_SCAN_CK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN_CK: n_state = i_stat.cnt_at_lim ? S_CLR : S_SCAN_W;
            S_SCAN_W:  n_state = S_SCAN_CK;
            S_CLR: begin
                if (i_stat.cnt_at_lim) n_state = S_RI_CHK;
            end
            S_RI_CHK: begin
                if (i_stat.cnt_at_lim) begin
                    case (r_ret)
                        RET_PLACE: n_state = S_PLACE_START;
                        RET_RM2:   n_state = S_RM_CHK2;
                        default:   n_state = S_IDLE;
                    endcase
                end else begin
                    n_state = S_RI_LD;
                end
            end
            S_RI_LD: begin
                n_mode  = MODE_REB;
                n_state = S_HASH;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = (r_state != S_IDLE);
        case (r_state)
            S_RST_CLR: begin
                if (!i_stat.cnt_at_lim) begin
                    o_cmd.wr_clr  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_IDLE: begin
                o_cmd.latch = start;
            end
            S_FETCH: begin
                if (i_stat.kind == KIND_FETCH && i_stat.range_bad) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_RANGE;
                end else if (i_stat.kind == KIND_FETCH) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_SLOT;
                end
            end
            S_FETCH_W: begin
                o_cmd.fin      = 1'b1;
                o_cmd.fin_fval = 1'b1;
            end
            S_HASH: begin
                if (i_stat.hash_done) o_cmd.probe_init = 1'b1;
                else                  o_cmd.hash_step  = 1'b1;
            end
            S_FIND_RD, S_PLC_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_PROBE;
            end
            S_FIND_CK: begin
                if (i_stat.rd_used && i_stat.key_match) begin
                    case (i_stat.kind)
                        KIND_SEARCH: begin
                            o_cmd.fin      = 1'b1;
                            o_cmd.fin_slot = 1'b1;
                        end
                        KIND_INSERT: begin
                            o_cmd.fin        = 1'b1;
                            o_cmd.fin_status = ST_EXISTS;
                        end
                        default: o_cmd.wr_tomb = 1'b1;
                    endcase
                end else if (i_stat.rd_empty || i_stat.probe_last) begin
                    if (i_stat.kind != KIND_INSERT) begin
                        o_cmd.fin        = 1'b1;
                        o_cmd.fin_status = i_stat.rd_empty ? ST_NOT_FOUND : ST_EXHAUSTED;
                    end
                end else begin
                    o_cmd.probe_next = 1'b1;
                end
            end
            S_GROW: begin
                if (i_stat.grow_need) begin
                    o_cmd.rb_start = 1'b1;
                    o_cmd.rb_grow  = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    o_cmd.n_clr    = 1'b1;
                    o_cmd.ld_lim   = 1'b1;
                    o_cmd.lim_sel  = LIM_SIZE;
                end
            end
            S_PLACE_START: o_cmd.ld_wk_req = 1'b1;
            S_PLC_CK: begin
                if (!i_stat.rd_used) begin
                    o_cmd.wr_place = 1'b1;
                    o_cmd.cnt_inc  = (r_mode == MODE_REB);
                end else if (i_stat.probe_last) begin
                    // no room: a rebuilt entry is dropped, a request is refused
                    if (r_mode == MODE_REB) begin
                        o_cmd.cnt_inc = 1'b1;
                    end else begin
                        o_cmd.fin        = 1'b1;
                        o_cmd.fin_status = ST_FULL;
                    end
                end else begin
                    o_cmd.probe_next = 1'b1;
                end
            end
            S_INS_FIN: begin
                o_cmd.fin      = 1'b1;
                o_cmd.fin_slot = 1'b1;
            end
            S_RM_CHK1, S_RM_CHK2: begin
                if ((r_state == S_RM_CHK1) ? i_stat.shrink_need : i_stat.tomb_need) begin
                    o_cmd.rb_start = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    o_cmd.n_clr    = 1'b1;
                    o_cmd.ld_lim   = 1'b1;
                    o_cmd.lim_sel  = LIM_SIZE;
                end else if (r_state == S_RM_CHK2) begin
                    o_cmd.fin = 1'b1;
                end
            end
            S_SCAN_CK: begin
                if (i_stat.cnt_at_lim) begin
                    o_cmd.cnt_clr = 1'b1;
                    o_cmd.ld_lim  = 1'b1;
                    o_cmd.lim_sel = LIM_CLR;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_CNT;
                end
            end
            S_SCAN_W: begin
                o_cmd.scr_wr  = i_stat.rd_used;
                o_cmd.cnt_inc = 1'b1;
            end
            S_CLR: begin
                if (i_stat.cnt_at_lim) begin
                    o_cmd.set_size = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    o_cmd.ld_lim   = 1'b1;
                    o_cmd.lim_sel  = LIM_NUM;
                end else begin
                    o_cmd.wr_clr  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_RI_CHK: begin
                if (i_stat.cnt_at_lim) begin
                    o_cmd.fin = (r_ret == RET_FIN);
                end else begin
                    o_cmd.scr_rd = 1'b1;
                end
            end
            S_RI_LD: o_cmd.ld_wk_scr = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/core/open_addressing_hash_table_top.sv
// Key/value hash table with open addressing and linear probing, FNV-1a over the
// key bytes. An item is taken when start is high and busy is low; its one result
// appears on o_result for a single cycle with o_done high and cannot be stalled.
// Each probe step is a memory read, then a check, and the hash takes the key
// bytes one after another. A resize holds busy while it collects the live
// entries over the old size, clears max(old, new) size slots and re-inserts
// each live entry, as it walks the slot memory. After reset a clearing pass
// over all MAX_SLOTS slots runs with busy high; configuration writes are
// taken at any time.
// depends on oaht_pkg, oaht_ctrl, oaht_dp
module open_addressing_hash_table_top #(
    parameter int MAX_SLOTS = 1024,
    parameter int KEY_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  oaht_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [8:0]        i_cfg_data,
    output logic              o_done,
    output oaht_pkg::t_result o_result
);
    import oaht_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    oaht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    oaht_dp #(
        .MAX_SLOTS (MAX_SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

// File: dv/oaht_checker.sv
// oaht_checker: watches the item and result channels of the hash table,
// keeps its own copy of the table and compares every result in order
// depends on oaht_pkg
module oaht_checker
    import oaht_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    parameter int KEY_BYTES = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_item   i_item,
    input  logic    i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    input  logic    i_done,
    input  t_result i_result,
    output int      o_errors,
    output int      o_pending
);

    t_flag       tbl_flag [MAX_SLOTS];
    logic [31:0] tbl_hash [MAX_SLOTS];
    logic [31:0] tbl_key  [MAX_SLOTS];
    logic [31:0] tbl_val  [MAX_SLOTS];
    logic        tbl_wr   [MAX_SLOTS];
    logic        all_wr;
    logic        fv_care;
    int unsigned size_lg, used_cnt, live_cnt;
    int unsigned grow_f, shrink_f, tomb_f;
    t_result     expected_q [$];
    logic        care_q [$];

    function automatic logic [31:0] fnv1a(input logic [31:0] key);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < KEY_BYTES; i++) begin
            h = h ^ {24'd0, key[8*i +: 8]};
            h = h * FNV_MULT;
        end
        return h;
    endfunction

    function automatic int unsigned slots();
        return 1 << size_lg;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            tbl_flag[i] = FLAG_EMPTY;
            tbl_hash[i] = '0;
            tbl_key[i]  = '0;
            tbl_val[i]  = '0;
        end
        used_cnt = 0;
        live_cnt = 0;
    endfunction

    function automatic void lookup(input logic [31:0] key, output t_status st,
                                   output int unsigned where);
        logic [31:0] h;
        int unsigned idx;
        h = fnv1a(key);
        st = ST_EXHAUSTED;
        where = 0;
        for (int unsigned i = 0; i < slots(); i++) begin
            idx = (h + i) & (slots() - 1);
            if (tbl_flag[idx] == FLAG_USED) begin
                if (tbl_hash[idx] == h && tbl_key[idx] == key) begin
                    st = ST_OK;
                    where = idx;
                    return;
                end
            end else if (tbl_flag[idx] == FLAG_EMPTY) begin
                st = ST_NOT_FOUND;
                return;
            end
        end
    endfunction

    function automatic void place(input logic [31:0] key, input logic [31:0] val,
                                  output logic ok, output int unsigned where);
        logic [31:0] h;
        int unsigned idx;
        h = fnv1a(key);
        ok = 1'b0;
        where = 0;
        for (int unsigned i = 0; i < slots(); i++) begin
            idx = (h + i) & (slots() - 1);
            if (tbl_flag[idx] != FLAG_USED) begin
                if (tbl_flag[idx] == FLAG_EMPTY) used_cnt++;
                live_cnt++;
                tbl_flag[idx] = FLAG_USED;
                tbl_hash[idx] = h;
                tbl_key[idx]  = key;
                tbl_val[idx]  = val;
                tbl_wr[idx]   = 1'b1;
                ok = 1'b1;
                where = idx;
                return;
            end
        end
    endfunction

    // collect live entries in slot order, clear, reinsert at new size
    function automatic void resize(input int unsigned new_lg);
        logic [31:0] keys [$];
        logic [31:0] vals [$];
        logic ok;
        int unsigned w;
        for (int unsigned i = 0; i < slots(); i++) begin
            if (tbl_flag[i] == FLAG_USED) begin
                keys.push_back(tbl_key[i]);
                vals.push_back(tbl_val[i]);
            end
        end
        clear_table();
        all_wr = 1'b1;
        size_lg = new_lg;
        foreach (keys[i]) place(keys[i], vals[i], ok, w);
    endfunction

    // fv_care drops to zero for a fetch of a slot never written
    function automatic t_result predict_op(input t_item it);
        t_result r;
        t_status st;
        int unsigned where;
        logic ok;
        r = '0;
        st = ST_OK;
        fv_care = 1'b1;
        case (t_kind'(it.kind))
            KIND_SEARCH: begin
                lookup(it.key, st, where);
                if (st == ST_OK) r.slot_out = SLOT_W'(where);
            end
            KIND_INSERT: begin
                lookup(it.key, st, where);
                if (st == ST_OK) begin
                    st = ST_EXISTS;
                end else begin
                    st = ST_OK;
                    if ((used_cnt + 1) * 256 > slots() * grow_f &&
                        slots() * 2 <= MAX_SLOTS)
                        resize(size_lg + 1);
                    place(it.key, it.new_value, ok, where);
                    if (ok) r.slot_out = SLOT_W'(where);
                    else st = ST_FULL;
                end
            end
            KIND_REMOVE: begin
                lookup(it.key, st, where);
                if (st == ST_OK) begin
                    tbl_flag[where] = FLAG_TOMB;
                    live_cnt--;
                    if (live_cnt * 256 < slots() * shrink_f)
                        resize(size_lg > 1 ? size_lg - 1 : 1);
                    if (live_cnt * 256 < used_cnt * tomb_f)
                        resize(size_lg > 1 ? size_lg - 1 : 1);
                end
            end
            default: begin
                if (it.slot_in >= slots()) begin
                    st = ST_RANGE;
                end else begin
                    r.found_value = tbl_val[it.slot_in];
                    fv_care = all_wr || tbl_wr[it.slot_in];
                end
            end
        endcase
        r.status = st;
        r.table_size = 11'(slots());
        r.active_count = 11'(live_cnt);
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        clear_table();
        for (int i = 0; i < MAX_SLOTS; i++) tbl_wr[i] = 1'b0;
        all_wr = 1'b0;
        size_lg = 1;
        grow_f = 192;
        shrink_f = 64;
        tomb_f = 128;
    end

    always @(posedge i_clk) begin
        t_result e;
        logic    c;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GROW:      grow_f = i_cfg_data;
                    CFG_SHRINK:    shrink_f = i_cfg_data[7:0];
                    CFG_TOMBSTONE: tomb_f = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", 32'(i_result.status), 32'd0);
                end else begin
                    e = expected_q.pop_front();
                    c = care_q.pop_front();
                    if (i_result.status != e.status)
                        report("status", 32'(i_result.status), 32'(e.status));
                    if (i_result.slot_out != e.slot_out)
                        report("slot_out", 32'(i_result.slot_out), 32'(e.slot_out));
                    if (c && i_result.found_value != e.found_value)
                        report("found_value", i_result.found_value, e.found_value);
                    if (i_result.table_size != e.table_size)
                        report("table_size", 32'(i_result.table_size),
                               32'(e.table_size));
                    if (i_result.active_count != e.active_count)
                        report("active_count", 32'(i_result.active_count),
                               32'(e.active_count));
                end
            end
            if (i_start && !i_busy) begin
                expected_q.push_back(predict_op(i_item));
                care_q.push_back(fv_care);
            end
            o_pending = expected_q.size();
        end
    end

endmodule

// File: dv/open_addressing_hash_table_top_test.sv
// open_addressing_hash_table_top_test: drives items and register writes into the
// hash table and gives the verdict from the failure count of oaht_checker
// depends on oaht_pkg, oaht_checker, open_addressing_hash_table_top
module open_addressing_hash_table_top_test;
    import oaht_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_item      item = '0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_idx = '0;
    logic [8:0] cfg_data = '0;
    logic       done;
    t_result    result;
    int         errors, pending;
    logic [31:0] key_pool [$];
    logic        calm;

    open_addressing_hash_table_top DUT (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy), .i_item(item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_done(done), .o_result(result)
    );

    oaht_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_item(item), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_done(done), .i_result(result),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one item, start raised only once busy is low so it is taken at the next edge
    task automatic send(input t_kind kind, input logic [31:0] key,
                        input logic [31:0] val, input logic [9:0] sl);
        if (!calm && $urandom_range(99) < 6) repeat ($urandom_range(1, 8)) @(negedge clk);
        while (busy) @(negedge clk);
        item.kind <= kind;
        item.key <= key;
        item.new_value <= val;
        item.slot_in <= sl;
        start <= 1'b1;
        @(negedge clk);
        start <= 1'b0;
    endtask

    // drain all outstanding results, then let a resize in flight finish
    task automatic quiesce();
        while (pending != 0) @(negedge clk);
        while (busy) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        quiesce();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(99) < 70)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        return $urandom();
    endfunction

    task automatic random_phase(input int n, input int pool_max);
        logic [31:0] k;
        int r;
        for (int i = 0; i < n; i++) begin
            calm = (i >= n / 3 && i < n / 2);
            k = pick_key();
            r = $urandom_range(99);
            if (r < 40) begin
                send(KIND_INSERT, k, $urandom(), $urandom());
                if (key_pool.size() < pool_max) key_pool.push_back(k);
            end else if (r < 65) begin
                send(KIND_REMOVE, k, $urandom(), $urandom());
            end else if (r < 85) begin
                send(KIND_SEARCH, k, $urandom(), $urandom());
            end else begin
                // any slot; the checker ignores the value of a slot never written
                send(KIND_FETCH, $urandom(), $urandom(), $urandom_range(1023));
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        calm = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: extremes, each kind, fetch range, exists, not found
        send(KIND_SEARCH, 32'h0, 32'h0, 10'h0);
        send(KIND_INSERT, 32'h0, 32'hFFFF_FFFF, 10'h3FF);
        send(KIND_INSERT, 32'hFFFF_FFFF, 32'h0, 10'h0);
        send(KIND_INSERT, 32'h0, 32'h1234, 10'h0);
        send(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0, 10'h0);
        send(KIND_FETCH, 32'h0, 32'h0, 10'h0);
        send(KIND_FETCH, 32'h0, 32'h0, 10'h1);
        send(KIND_FETCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        send(KIND_REMOVE, 32'h0, 32'h0, 10'h0);
        send(KIND_FETCH, 32'h0, 32'h0, 10'h0);
        send(KIND_REMOVE, 32'h0, 32'h0, 10'h0);
        send(KIND_SEARCH, 32'h5555_AAAA, 32'h0, 10'h0);
        send(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 10'h0);
        // grow factor 256: the table grows only once every slot has been used
        write_reg(CFG_GROW, 9'd256);
        write_reg(CFG_SHRINK, 8'd0);
        write_reg(CFG_TOMBSTONE, 8'd0);
        send(KIND_INSERT, 32'h11, 32'h1, 10'h0);
        send(KIND_INSERT, 32'h22, 32'h2, 10'h0);
        send(KIND_INSERT, 32'h33, 32'h3, 10'h0);
        send(KIND_SEARCH, 32'h44, 32'h0, 10'h0);
        send(KIND_REMOVE, 32'h11, 32'h0, 10'h0);
        send(KIND_SEARCH, 32'h44, 32'h0, 10'h0);
        send(KIND_INSERT, 32'h44, 32'h4, 10'h0);
        // grow 0 doubles on each insert up to capacity
        write_reg(CFG_GROW, 9'd0);
        for (int i = 0; i < 11; i++) send(KIND_INSERT, $urandom(), $urandom(), 10'h0);
        write_reg(CFG_SHRINK, 8'd255);
        write_reg(CFG_TOMBSTONE, 8'd255);
        send(KIND_REMOVE, 32'h22, 32'h0, 10'h0);
        quiesce();
        // random phases at several settings
        write_reg(CFG_GROW, 9'd192);
        write_reg(CFG_SHRINK, 8'd64);
        write_reg(CFG_TOMBSTONE, 8'd128);
        random_phase(200, 24);
        key_pool.delete();
        write_reg(CFG_GROW, 9'd511);
        write_reg(CFG_SHRINK, 8'd1);
        write_reg(CFG_TOMBSTONE, 8'd1);
        random_phase(130, 12);
        key_pool.delete();
        write_reg(CFG_GROW, 9'd1);
        write_reg(CFG_SHRINK, 8'd128);
        write_reg(CFG_TOMBSTONE, 8'd200);
        random_phase(110, 16);
        write_reg(CFG_GROW, 9'd128);
        write_reg(CFG_SHRINK, 8'd32);
        write_reg(CFG_TOMBSTONE, 8'd64);
        random_phase(90, 40);
        quiesce();
        repeat (50) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/oaht_pkg.sv
rtl/core/oaht_dp.sv
rtl/core/oaht_ctrl.sv
rtl/core/open_addressing_hash_table_top.sv
dv/oaht_checker.sv
dv/open_addressing_hash_table_top_test.sv
